@@ rtl/pbcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcp_pkg
// Shared types and constants for the page buffer circle plotter: command
// codes and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pbcp_pkg;

    // Command codes carried by the operation field.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_SET   = 2'd1,
        OP_DRAW  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Pixel rows held in one page byte.
    localparam int ROWS_PER_PAGE = 8;

    // Width of the signed midpoint error term a*a + b*b - r*r.
    localparam int ERR_W = 19;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // latch the input transaction and reset ring walk
        logic clr_step;   // write zero at the sweep address and advance
        logic pt_read;    // read the byte that holds the current point
        logic pt_center;  // current point is the centre itself
        logic pt_write;   // write back the byte with the point set
        logic ring_next;  // move on to the next smaller ring
        logic rd_issue;   // read the byte addressed by a read transaction
        logic res_load;   // load the result register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;   // sweep address is the last entry
        logic oct_last;   // last of the eight symmetric points
        logic step_more;  // ring walk continues after this step
        logic last_ring;  // current ring is the final one
        logic no_rings;   // ring count is zero
        logic out_free;   // result register can take a new result
    } status_t;

endpackage

@@ rtl/pbcp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcp_ctrl
// Command sequencer. Runs the clearing sweep after reset, then takes one
// transaction at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module pbcp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         operation,
    input  pbcp_pkg::status_t  status,
    output pbcp_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_CLEAR,
        S_SET_RD,
        S_SET_WR,
        S_RING_CHK,
        S_PT_RD,
        S_PT_WR,
        S_RD_ISSUE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_INIT_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    case (pbcp_pkg::op_t'(operation))
                        pbcp_pkg::OP_CLEAR: state_next = S_CLEAR;
                        pbcp_pkg::OP_SET:   state_next = S_SET_RD;
                        pbcp_pkg::OP_DRAW:  state_next = S_RING_CHK;
                        pbcp_pkg::OP_READ:  state_next = S_RD_ISSUE;
                        default:            state_next = S_FINISH;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SET_RD:
            begin
                cmd.pt_read   = 1'b1;
                cmd.pt_center = 1'b1;
                state_next    = S_SET_WR;
            end
            S_SET_WR:
            begin
                cmd.pt_write = 1'b1;
                state_next   = S_FINISH;
            end
            S_RING_CHK:
            begin
                state_next = status.no_rings ? S_FINISH : S_PT_RD;
            end
            S_PT_RD:
            begin
                cmd.pt_read = 1'b1;
                state_next  = S_PT_WR;
            end
            S_PT_WR:
            begin
                cmd.pt_write = 1'b1;
                if (!status.oct_last || status.step_more)
                begin
                    state_next = S_PT_RD;
                end
                else if (status.last_ring)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.ring_next = 1'b1;
                    state_next    = S_PT_RD;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Only one transaction is in flight.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("pbcp_ctrl: new transaction taken while one is in flight");

    // Input opens only after a result is posted or the startup sweep ends.
    a_ready_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_ready) |-> ($past(cmd.res_load) || $past(state_reg == S_INIT_CLR)))
        else $error("pbcp_ctrl: input opened without a posted result");

    // A result is posted only when the output register can take it.
    a_post_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> status.out_free)
        else $error("pbcp_ctrl: result posted over a waiting one");

endmodule

@@ rtl/pbcp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcp_datapath
// Frame memory, clear sweep counter, midpoint ring walker, point address
// generation and the result register.
// ----------------------------------------------------------------------------
module pbcp_datapath
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pbcp_pkg::cmd_t     cmd,
    output pbcp_pkg::status_t  status,
    input  logic [1:0]         operation,
    input  logic [7:0]         x_pos,
    input  logic [7:0]         y_pos,
    input  logic [7:0]         radius,
    input  logic [7:0]         ring_count,
    input  logic [2:0]         read_page,
    input  logic [6:0]         read_column,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [7:0]         read_data,
    output logic               read_valid
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = PW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int ErrW  = pbcp_pkg::ERR_W;
    localparam logic [8:0] ColLimit = 9'(COLUMNS);
    localparam logic [8:0] RowLimit = 9'(PAGES * pbcp_pkg::ROWS_PER_PAGE);
    localparam logic [5:0] PageLimit = 6'(PAGES);

    // Latched transaction.
    logic [1:0]  op_reg;
    logic [7:0]  cx_reg;
    logic [7:0]  cy_reg;
    logic [7:0]  r_reg;
    logic [7:0]  n_reg;
    logic [2:0]  rpg_reg;
    logic [6:0]  rcol_reg;

    // Ring walk.
    logic [8:0]             a_reg;
    logic [7:0]             b_reg;
    logic signed [ErrW-1:0] err_reg;
    logic [2:0]             oct_reg;

    // Sweep and point write-back.
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] pt_addr_reg;
    logic [7:0]    pt_mask_reg;
    logic          pt_ok_reg;

    // Result register.
    logic       result_valid_reg;
    logic [7:0] read_data_reg;
    logic       read_valid_reg;

    // Frame memory.
    logic [7:0]    frame_mem [DEPTH];
    logic [7:0]    mem_rd_data_reg;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;

    // Step of the midpoint walk: a advances, b drops when the point leaves
    // the circle, with the error term kept exact by increments.
    logic [8:0]             a_inc;
    logic signed [ErrW-1:0] err_a;
    logic                   b_dec;
    logic [8:0]             two_b_m1;
    logic [7:0]             b_step;
    logic signed [ErrW-1:0] err_step;

    assign a_inc    = a_reg + 9'd1;
    assign err_a    = err_reg + $signed(ErrW'({a_reg, 1'b1}));
    assign b_dec    = (err_a > 0) && (b_reg != 8'd0);
    assign two_b_m1 = {b_reg, 1'b0} - 9'd1;
    assign b_step   = b_dec ? (b_reg - 8'd1) : b_reg;
    assign err_step = b_dec ? (err_a - $signed(ErrW'(two_b_m1))) : err_a;

    // Current point, wrapped to eight bits.
    logic [7:0]    a8;
    logic [7:0]    px;
    logic [7:0]    py;
    logic          pt_ok;
    logic [AW-1:0] pt_addr;
    logic          rd_ok;
    logic [AW-1:0] rd_addr;

    assign a8 = a_reg[7:0];

    always_comb
    begin
        if (cmd.pt_center)
        begin
            px = cx_reg;
            py = cy_reg;
        end
        else
        begin
            case (oct_reg)
                3'd0:    begin px = cx_reg - b_reg; py = cy_reg - a8;    end
                3'd1:    begin px = cx_reg - b_reg; py = cy_reg + a8;    end
                3'd2:    begin px = cx_reg - a8;    py = cy_reg + b_reg; end
                3'd3:    begin px = cx_reg - a8;    py = cy_reg - b_reg; end
                3'd4:    begin px = cx_reg + b_reg; py = cy_reg - a8;    end
                3'd5:    begin px = cx_reg + b_reg; py = cy_reg + a8;    end
                3'd6:    begin px = cx_reg + a8;    py = cy_reg + b_reg; end
                default: begin px = cx_reg + a8;    py = cy_reg - b_reg; end
            endcase
        end
    end

    assign pt_ok   = ({1'b0, px} < ColLimit) && ({1'b0, py} < RowLimit);
    assign pt_addr = {PW'(py[7:3]), CW'(px)};
    assign rd_ok   = ({3'b000, rpg_reg} < PageLimit) && ({2'b00, rcol_reg} < ColLimit);
    assign rd_addr = {PW'(rpg_reg), CW'(rcol_reg)};

    // Memory port control.
    assign mem_wr_en   = cmd.clr_step || (cmd.pt_write && pt_ok_reg);
    assign mem_wr_addr = cmd.clr_step ? clr_addr_reg : pt_addr_reg;
    assign mem_wr_data = cmd.clr_step ? 8'h00 : (mem_rd_data_reg | pt_mask_reg);
    assign mem_rd_en   = cmd.pt_read || (cmd.rd_issue && rd_ok);
    assign mem_rd_addr = cmd.rd_issue ? rd_addr : pt_addr;

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            frame_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            mem_rd_data_reg <= frame_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            a_reg            <= '0;
            b_reg            <= '0;
            err_reg          <= '0;
            r_reg            <= '0;
            oct_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end

            if (cmd.load)
            begin
                r_reg   <= radius;
                a_reg   <= '0;
                b_reg   <= radius;
                err_reg <= '0;
                oct_reg <= '0;
            end
            else if (cmd.ring_next)
            begin
                r_reg   <= r_reg - 8'd1;
                a_reg   <= '0;
                b_reg   <= r_reg - 8'd1;
                err_reg <= '0;
                oct_reg <= '0;
            end
            else if (cmd.pt_write)
            begin
                oct_reg <= oct_reg + 3'd1;
                if (oct_reg == 3'd7)
                begin
                    a_reg   <= a_inc;
                    b_reg   <= b_step;
                    err_reg <= err_step;
                end
            end

            if (cmd.res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            cx_reg   <= x_pos;
            cy_reg   <= y_pos;
            n_reg    <= ring_count;
            rpg_reg  <= read_page;
            rcol_reg <= read_column;
        end
        else if (cmd.ring_next)
        begin
            n_reg <= n_reg - 8'd1;
        end

        if (cmd.pt_read)
        begin
            pt_addr_reg <= pt_addr;
            pt_mask_reg <= 8'(1) << py[2:0];
            pt_ok_reg   <= pt_ok;
        end

        if (cmd.res_load)
        begin
            if ((pbcp_pkg::op_t'(op_reg) == pbcp_pkg::OP_READ) && rd_ok)
            begin
                read_data_reg  <= mem_rd_data_reg;
                read_valid_reg <= 1'b1;
            end
            else
            begin
                read_data_reg  <= 8'h00;
                read_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clr_last  = &clr_addr_reg;
    assign status.oct_last  = (oct_reg == 3'd7);
    assign status.step_more = (a_inc <= {1'b0, b_step});
    assign status.last_ring = (n_reg == 8'd1) || (r_reg == 8'd0);
    assign status.no_rings  = (n_reg == 8'd0);
    assign status.out_free  = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign read_data    = read_data_reg;
    assign read_valid   = read_valid_reg;

    // The incremental error term always equals a*a + b*b - r*r.
    a_err_exact: assert property (@(posedge clk) disable iff (!rst_n)
        ((21'(a_reg) * 21'(a_reg)) + (21'(b_reg) * 21'(b_reg))
         - (21'(r_reg) * 21'(r_reg))) == 21'(err_reg))
        else $error("pbcp_datapath: ring error term drifted");

    // Only a read result carries data.
    a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (read_data != 8'h00)) |-> read_valid)
        else $error("pbcp_datapath: data on a result that is not a read");

    // A result appears only when the controller posts one.
    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.res_load))
        else $error("pbcp_datapath: result appeared without a post");

endmodule

@@ rtl/page_buffer_circle_plotter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_buffer_circle_plotter_core
// Monochrome page frame store with pixel set, byte read, clear and a
// concentric circle ring plotter, behind valid/ready channels.
// ----------------------------------------------------------------------------
// The block holds PAGES pages of COLUMNS bytes; bit y mod 8 of byte
// [y/8][x] is the pixel at (x, y). Each input transaction gives exactly one
// result transaction, and transactions are handled one at a time. The frame
// memory has one write and one read port, and every pixel is a
// read-modify-write through it, so the memory port sets the rate: each
// point of a ring or a set pixel is a read and then a write-back, a byte
// read is a single read, and a clear writes zero to every one of the
// 2**(clog2(PAGES)+clog2(COLUMNS)) entries (1024 with the defaults) in turn.
// After reset the block runs the same clearing sweep and holds item_ready
// low until the sweep ends. A finished result waits in an output register,
// so a stalled result side does not lose data; the next transaction is
// taken once it is posted. Points wrap modulo 256 and are dropped outside
// the store; a read outside the store returns read_valid low and read_data
// zero.
// ----------------------------------------------------------------------------
module page_buffer_circle_plotter_core
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
)
(
    input  logic       clk,
    input  logic       rst_n,

    // Command channel.
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] operation,
    input  logic [7:0] x_pos,
    input  logic [7:0] y_pos,
    input  logic [7:0] radius,
    input  logic [7:0] ring_count,
    input  logic [2:0] read_page,
    input  logic [6:0] read_column,

    // Result channel.
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] read_data,
    output logic       read_valid
);

    pbcp_pkg::cmd_t    cmd;
    pbcp_pkg::status_t status;

    // The controller sequences sweeps, point read-modify-writes and ring
    // steps; the datapath owns the memory and all arithmetic.
    pbcp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .status     (status),
        .cmd        (cmd)
    );

    pbcp_datapath
    #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .radius       (radius),
        .ring_count   (ring_count),
        .read_page    (read_page),
        .read_column  (read_column),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .read_valid   (read_valid)
    );

endmodule

@@ tb/tb_page_buffer_circle_plotter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_buffer_circle_plotter_core
// Self-checking bench for the page frame store and circle ring plotter.
// ----------------------------------------------------------------------------
// A short table of directed commands covers reads after reset, pixels at the
// edges of the store, points that fall outside it, the centre-only ring, a
// zero ring count, ring sequences cut short at radius zero, the widest
// radius and a clear. Many random commands follow. A private pixel image
// tracks every accepted command and predicts each result transaction.
// Both channels idle in random bursts, and the result side holds off once
// for a long stretch so that the block backs up into its command channel.
// ----------------------------------------------------------------------------
module tb_page_buffer_circle_plotter_core;

    // Command codes, taken from the shared package.
    localparam pbcp_pkg::op_t OP_CLEAR = pbcp_pkg::OP_CLEAR;
    localparam pbcp_pkg::op_t OP_SET   = pbcp_pkg::OP_SET;
    localparam pbcp_pkg::op_t OP_DRAW  = pbcp_pkg::OP_DRAW;
    localparam pbcp_pkg::op_t OP_READ  = pbcp_pkg::OP_READ;

    // Geometry of the store; these match the block's default parameters.
    localparam int COLS       = 128;
    localparam int PAGE_COUNT = 8;
    localparam int IMAGE_SIZE = COLS * PAGE_COUNT;

    // Random commands after the directed table, and how many of the last
    // ones run with no idling on either side.
    localparam int RANDOM_ITEMS = 1625;
    localparam int CALM_ITEMS   = 150;

    // The long result-side hold that makes the block stall its input.
    localparam int HOLD_CYCLES = 300;

    // Cycles allowed after the last result before the verdict.
    localparam int DRAIN_CYCLES = 64;

    // Generous bound: the reset sweep, every clear, the few wide rings and
    // the worst idling together stay far below this.
    localparam int CYCLE_LIMIT = 4000000;

    localparam int DIRECTED_COUNT = 24;

    // One command as it appears on the command channel.
    typedef struct {
        pbcp_pkg::op_t op;
        logic [7:0]    x;
        logic [7:0]    y;
        logic [7:0]    r;
        logic [7:0]    n;
        logic [2:0]    pg;
        logic [6:0]    col;
    } plot_cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } readback_t;

    // A directed row: the command, plus an expected result where it is
    // obvious by inspection. Rows without one are left to the predictor.
    typedef struct {
        pbcp_pkg::op_t op;
        logic [7:0]    x;
        logic [7:0]    y;
        logic [7:0]    r;
        logic [7:0]    n;
        logic [2:0]    pg;
        logic [6:0]    col;
        bit            typed;
        logic [7:0]    want_data;
        bit            want_valid;
    } plot_row_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [1:0] operation;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] radius;
    logic [7:0] ring_count;
    logic [2:0] read_page;
    logic [6:0] read_column;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] read_data;
    logic       read_valid;

    // Predicted pixel image and the results still owed by the block.
    logic [7:0] frame_image [0:IMAGE_SIZE-1];
    readback_t  pending_readbacks [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  squeeze_now    = 1'b0;
    bit  calm_tail      = 1'b0;
    bit  gaps_enabled   = 1'b0;

    plot_row_t directed_rows [DIRECTED_COUNT] = '{
        // Reads straight after reset: the store must be empty.
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd0, 7'd0,   1'b1, 8'h00, 1'b1},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd7, 7'd127, 1'b1, 8'h00, 1'b1},
        // The two corner pixels of the store.
        '{OP_SET,   8'd0,   8'd0,   8'd0,   8'd0,   3'd0, 7'd0,   1'b1, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd0, 7'd0,   1'b1, 8'h01, 1'b1},
        '{OP_SET,   8'd127, 8'd63,  8'd0,   8'd0,   3'd0, 7'd0,   1'b1, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd7, 7'd127, 1'b1, 8'h80, 1'b1},
        // Pixels just past the right and bottom edges, and the far corner,
        // are all dropped.
        '{OP_SET,   8'd128, 8'd0,   8'd0,   8'd0,   3'd0, 7'd0,   1'b1, 8'h00, 1'b0},
        '{OP_SET,   8'd255, 8'd255, 8'd0,   8'd0,   3'd0, 7'd0,   1'b1, 8'h00, 1'b0},
        '{OP_SET,   8'd5,   8'd64,  8'd0,   8'd0,   3'd0, 7'd0,   1'b1, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd0, 7'd5,   1'b1, 8'h00, 1'b1},
        // Radius zero with three rings asked: only the centre is set.
        '{OP_DRAW,  8'd10,  8'd10,  8'd0,   8'd3,   3'd0, 7'd0,   1'b1, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd1, 7'd10,  1'b1, 8'h04, 1'b1},
        // A zero ring count draws nothing, so the ring's rightmost point
        // stays clear.
        '{OP_DRAW,  8'd20,  8'd20,  8'd4,   8'd0,   3'd0, 7'd0,   1'b1, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd2, 7'd24,  1'b1, 8'h00, 1'b1},
        // A ring count far above the radius stops after radius zero.
        '{OP_DRAW,  8'd64,  8'd32,  8'd3,   8'd200, 3'd5, 7'd99,  1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd4, 7'd67,  1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd4, 7'd64,  1'b0, 8'h00, 1'b0},
        // Widest radius from a centre outside the store; points wrap.
        '{OP_DRAW,  8'd200, 8'd200, 8'd255, 8'd2,   3'd2, 7'd17,  1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd3, 7'd100, 1'b0, 8'h00, 1'b0},
        // A small ring around the bottom right corner, mostly clipped.
        '{OP_DRAW,  8'd127, 8'd63,  8'd1,   8'd1,   3'd0, 7'd0,   1'b0, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd7, 7'd126, 1'b0, 8'h00, 1'b0},
        // Clear, then reads that must come back empty.
        '{OP_CLEAR, 8'd9,   8'd9,   8'd9,   8'd9,   3'd7, 7'd127, 1'b1, 8'h00, 1'b0},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd4, 7'd64,  1'b1, 8'h00, 1'b1},
        '{OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   3'd7, 7'd127, 1'b1, 8'h00, 1'b1}
    };

    page_buffer_circle_plotter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .radius       (radius),
        .ring_count   (ring_count),
        .read_page    (read_page),
        .read_column  (read_column),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .read_valid   (read_valid)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Reset is held low from time zero and released on a falling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("page_buffer_circle_plotter_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Pixel image predictor
    // ------------------------------------------------------------------------

    // Sets one pixel. Coordinates wrap to eight bits; anything right of the
    // last column or below the last row is dropped.
    function automatic void mark_pixel(int unsigned px, int unsigned py);
        logic [7:0] xw;
        logic [7:0] yw;
        int         idx;
        xw = 8'(px);
        yw = 8'(py);
        if (xw >= COLS || yw >= PAGE_COUNT * 8)
            return;
        idx = (yw >> 3) * COLS + xw;
        frame_image[idx] = frame_image[idx] | (8'h01 << yw[2:0]);
    endfunction

    // One midpoint ring: a walks up from zero, b down from the radius, and
    // each step sets the eight mirror points. A zero radius is the centre.
    function automatic void trace_ring(int unsigned cx, int unsigned cy, int unsigned r);
        int unsigned a;
        int unsigned b;
        int unsigned r_sq;
        a = 0;
        b = r;
        r_sq = r * r;
        if (r == 0)
        begin
            mark_pixel(cx, cy);
            return;
        end
        while (a <= b)
        begin
            mark_pixel(cx - b, cy - a);
            mark_pixel(cx - b, cy + a);
            mark_pixel(cx - a, cy + b);
            mark_pixel(cx - a, cy - b);
            mark_pixel(cx + b, cy - a);
            mark_pixel(cx + b, cy + a);
            mark_pixel(cx + a, cy + b);
            mark_pixel(cx + a, cy - b);
            a++;
            if (a * a + b * b > r_sq && b > 0)
                b--;
        end
    endfunction

    // Applies one command to the image and returns the result it must give.
    function automatic readback_t predict_readback(plot_cmd_t c);
        readback_t   rb;
        int unsigned rad;
        int unsigned rings_left;
        rb = '0;
        case (c.op)
            OP_CLEAR:
            begin
                foreach (frame_image[i])
                    frame_image[i] = 8'h00;
            end
            OP_SET:
                mark_pixel(c.x, c.y);
            OP_DRAW:
            begin
                // Rings shrink by one; the sequence ends at radius zero
                // instead of wrapping.
                rad = c.r;
                rings_left = c.n;
                while (rings_left > 0)
                begin
                    trace_ring(c.x, c.y, rad);
                    rings_left--;
                    if (rad == 0)
                        break;
                    rad--;
                end
            end
            default:
            begin
                if (c.pg < PAGE_COUNT && c.col < COLS)
                begin
                    rb.data  = frame_image[c.pg * COLS + c.col];
                    rb.valid = 1'b1;
                end
            end
        endcase
        return rb;
    endfunction

    // ------------------------------------------------------------------------
    // Random commands
    // ------------------------------------------------------------------------

    // Reads dominate so that drawn pixels are actually observed. Most
    // pixels and centres land inside the store, the rest anywhere. Rings
    // are mostly small; a few use the top half of the radius range, and
    // some pair a tiny radius with any ring count so that the sequence
    // runs into radius zero. Unused fields carry noise.
    function automatic plot_cmd_t random_plot_cmd();
        plot_cmd_t c;
        int        pick;
        c.x   = 8'($urandom);
        c.y   = 8'($urandom);
        c.r   = 8'($urandom);
        c.n   = 8'($urandom);
        c.pg  = 3'($urandom);
        c.col = 7'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 3)
            c.op = OP_CLEAR;
        else if (pick < 25)
        begin
            c.op = OP_SET;
            if ($urandom_range(0, 3) != 0)
            begin
                c.x = 8'($urandom_range(0, 127));
                c.y = 8'($urandom_range(0, 63));
            end
        end
        else if (pick < 55)
        begin
            c.op = OP_DRAW;
            if ($urandom_range(0, 3) != 0)
            begin
                c.x = 8'($urandom_range(0, 140));
                c.y = 8'($urandom_range(0, 80));
            end
            pick = $urandom_range(0, 49);
            if (pick == 0)
            begin
                c.r = 8'($urandom_range(128, 255));
                c.n = 8'($urandom_range(1, 2));
            end
            else if (pick < 5)
            begin
                c.r = 8'($urandom_range(0, 7));
                c.n = 8'($urandom_range(0, 255));
            end
            else
            begin
                c.r = 8'($urandom_range(0, 31));
                c.n = 8'($urandom_range(1, 3));
            end
        end
        else
            c.op = OP_READ;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Offers one command from a falling edge, waits for the handshake, books
    // the expected result and returns on the next falling edge. A typed
    // expectation replaces the predicted one, but the image is still updated.
    task automatic offer_cmd(input plot_cmd_t c, input bit typed, input readback_t typed_rb);
        readback_t rb;
        int        gap;
        if (!calm_tail && gaps_enabled && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation   = c.op;
        x_pos       = c.x;
        y_pos       = c.y;
        radius      = c.r;
        ring_count  = c.n;
        read_page   = c.pg;
        read_column = c.col;
        item_valid  = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        rb = predict_readback(c);
        if (typed)
            rb = typed_rb;
        pending_readbacks.push_back(rb);
        @(negedge clk);
    endtask

    initial
    begin
        plot_cmd_t c;
        readback_t typed_rb;
        item_valid  = 1'b0;
        operation   = OP_CLEAR;
        x_pos       = '0;
        y_pos       = '0;
        radius      = '0;
        ring_count  = '0;
        read_page   = '0;
        read_column = '0;
        foreach (frame_image[i])
            frame_image[i] = 8'h00;

        wait (rst_n === 1'b1);
        @(negedge clk);

        // Directed table, with idling already in play.
        gaps_enabled = 1'b1;
        for (int k = 0; k < DIRECTED_COUNT; k++)
        begin
            c.op  = directed_rows[k].op;
            c.x   = directed_rows[k].x;
            c.y   = directed_rows[k].y;
            c.r   = directed_rows[k].r;
            c.n   = directed_rows[k].n;
            c.pg  = directed_rows[k].pg;
            c.col = directed_rows[k].col;
            typed_rb.data  = directed_rows[k].want_data;
            typed_rb.valid = directed_rows[k].want_valid;
            offer_cmd(c, directed_rows[k].typed, typed_rb);
        end

        // The long result-side hold starts as the random commands begin.
        squeeze_now = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // Command-side idling switches on and off in stretches and
            // stops entirely for the final commands.
            if (k % 64 == 0)
                gaps_enabled = ($urandom_range(0, 2) != 0);
            calm_tail = (k >= RANDOM_ITEMS - CALM_ITEMS);
            offer_cmd(random_plot_cmd(), 1'b0, '0);
        end
        item_valid = 1'b0;

        while (pending_readbacks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("page_buffer_circle_plotter_core verification clean");
        else
            $display("page_buffer_circle_plotter_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Ready changes on falling edges. The stall rate is re-drawn at the start
    // of each span among none, light and heavy, so there are quiet stretches as
    // well as busy ones. The one long hold is counted here on its own.
    initial
    begin
        int hold;
        int stall_level;
        int span;
        bit squeeze_done;
        result_ready = 1'b0;
        stall_level  = 0;
        span         = 0;
        squeeze_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                span = 256;
                stall_level = $urandom_range(0, 2);
            end
            span--;
            if (squeeze_now && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                result_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm_tail && stall_level != 0
                     && $urandom_range(0, (stall_level == 1) ? 15 : 3) == 0)
            begin
                result_ready = 1'b0;
                hold = $urandom_range(1, 19);
                repeat (hold - 1) @(negedge clk);
            end
            else
                result_ready = 1'b1;
        end
    end

    // Every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        readback_t exp_rb;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_readbacks.size() == 0)
            begin
                $error("unexpected result transaction: read_data %0h read_valid %0b",
                       read_data, read_valid);
                mismatch_count++;
            end
            else
            begin
                exp_rb = pending_readbacks.pop_front();
                if (read_data !== exp_rb.data)
                begin
                    $error("read_data: expected %0h, got %0h", exp_rb.data, read_data);
                    mismatch_count++;
                end
                if (read_valid !== exp_rb.valid)
                begin
                    $error("read_valid: expected %0b, got %0b", exp_rb.valid, read_valid);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
